// ----- rtl/core/b64e_pkg.sv -----
package b64e_pkg;

  localparam logic [7:0] PAD_CHAR     = 8'd61;
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] WRAP_RESET   = 8'd64;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // one decoded byte: up to four characters, newlines not yet placed
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            is_last;
  } b64e_entry_t;

  // sextet to character of the standard alphabet
  function automatic logic [7:0] b64e_sextet_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'(8'd65 + {2'b00, v});
    end else if (v < 6'd52) begin
      r = 8'(8'd97 + {2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      r = 8'(8'd48 + {2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      r = 8'd43;
    end else begin
      r = 8'd47;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/base64_stream_encoder_unit.sv -----
// streaming base64 encoder, standard alphabet A-Z a-z 0-9 + /; takes one raw byte per request
// on s_axis and gives one character per request on m_axis, with m_axis_tlast on the final
// character caused by each byte; a byte with s_axis_tlast ends the message: the partial
// group is flushed with zero fill and '=' padding, and group phase and line column restart;
// before any character a newline (10) is sent once the line holds wrap_width characters
// (cfg port, reset 64, 0 turns wrapping off); a byte enters when the queue has room and its
// characters leave at one per cycle from the output register while m_axis_tready is high,
// so the sustained rate is set by the character count, newlines included; a two-entry queue
// lets input keep flowing while the output side is stalled
module base64_stream_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  // configuration: wrap_width
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  // input bytes
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // is_last
  // output characters
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // out_last
);

  logic [7:0] wrap_width;

  b64e_pkg::b64e_entry_t push_entry;
  b64e_pkg::b64e_entry_t head;
  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  head_valid;

  // wrap width register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_width <= b64e_pkg::WRAP_RESET;
    end else if (cfg_valid) begin
      wrap_width <= cfg_data;
    end
  end

  // front: tracks group phase and leftover bits, turns a byte into its characters
  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .data_byte (s_axis_tdata),
    .is_last   (s_axis_tlast),
    .full      (full),
    .push      (push),
    .entry     (push_entry)
  );

  // queue of decoded bytes between the two sides
  b64e_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: places newlines by line column and sends characters one per cycle while out_ready is high
  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wrap_width (wrap_width),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_char   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

// ----- rtl/core/b64e_front.sv -----
module b64e_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  is_last,
  input  logic                  full,
  output logic                  push,
  output b64e_pkg::b64e_entry_t entry
);

  logic [1:0] phase, phase_next;
  logic [3:0] leftover, leftover_next;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  always_comb begin
    entry         = '0;
    entry.is_last = is_last;
    phase_next    = phase;
    leftover_next = leftover;
    case (phase)
      2'd1: begin
        entry.chars[0] = b64e_pkg::b64e_sextet_char({leftover[1:0], data_byte[7:4]});
        entry.last_idx = 2'd0;
        leftover_next  = data_byte[3:0];
        phase_next     = 2'd2;
        if (is_last) begin
          entry.chars[1] = b64e_pkg::b64e_sextet_char({data_byte[3:0], 2'b00});
          entry.chars[2] = b64e_pkg::PAD_CHAR;
          entry.last_idx = 2'd2;
        end
      end
      2'd2: begin
        entry.chars[0] = b64e_pkg::b64e_sextet_char({leftover, data_byte[7:6]});
        entry.chars[1] = b64e_pkg::b64e_sextet_char(data_byte[5:0]);
        entry.last_idx = 2'd1;
        leftover_next  = 4'd0;
        phase_next     = 2'd0;
      end
      default: begin
        // phase zero, and the unused phase three acting as zero
        entry.chars[0] = b64e_pkg::b64e_sextet_char(data_byte[7:2]);
        entry.last_idx = 2'd0;
        leftover_next  = {2'b00, data_byte[1:0]};
        phase_next     = 2'd1;
        if (is_last) begin
          entry.chars[1] = b64e_pkg::b64e_sextet_char({data_byte[1:0], 4'b0000});
          entry.chars[2] = b64e_pkg::PAD_CHAR;
          entry.chars[3] = b64e_pkg::PAD_CHAR;
          entry.last_idx = 2'd3;
        end
      end
    endcase
    if (is_last) begin
      phase_next    = 2'd0;
      leftover_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 2'd0;
      leftover <= 4'd0;
    end else if (push) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

// ----- rtl/core/b64e_fifo.sv -----
module b64e_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64e_pkg::b64e_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output b64e_pkg::b64e_entry_t head
);

  b64e_pkg::b64e_entry_t slots [b64e_pkg::FIFO_DEPTH];

  logic [b64e_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [b64e_pkg::FIFO_CW-1:0] count;
  logic                         do_pop;

  assign full       = (count == b64e_pkg::FIFO_CW'(b64e_pkg::FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == b64e_pkg::FIFO_AW'(b64e_pkg::FIFO_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == b64e_pkg::FIFO_AW'(b64e_pkg::FIFO_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/b64e_back.sv -----
module b64e_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            wrap_width,
  input  logic                  head_valid,
  input  b64e_pkg::b64e_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char,
  output logic                  out_last
);

  logic [1:0] idx, idx_next;
  logic [7:0] col, col_next;
  logic [7:0] char_next;
  logic       last_next;
  logic       valid_next;
  logic       adv;
  logic       need_nl;
  logic       final_char;

  assign adv        = head_valid && (!out_valid || out_ready);
  assign need_nl    = (wrap_width != 8'd0) && (col >= wrap_width);
  assign final_char = (idx == head.last_idx);

  always_comb begin
    idx_next   = idx;
    col_next   = col;
    char_next  = out_char;
    last_next  = out_last;
    valid_next = out_valid && !out_ready;
    pop        = 1'b0;
    if (adv) begin
      valid_next = 1'b1;
      if (need_nl) begin
        char_next = b64e_pkg::NEWLINE_CHAR;
        last_next = 1'b0;
        col_next  = 8'd0;
      end else begin
        char_next = head.chars[idx];
        last_next = final_char;
        col_next  = (col == 8'd255) ? col : col + 8'd1;
        idx_next  = idx + 2'd1;
        if (final_char) begin
          pop      = 1'b1;
          idx_next = 2'd0;
          if (head.is_last) begin
            col_next = 8'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      col       <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      idx       <= idx_next;
      col       <= col_next;
      out_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_char <= char_next;
    out_last <= last_next;
  end

  a_idx_in_entry: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= head.last_idx)
    else $error("character index past end of entry");

  a_nl_clears_col: assert property (@(posedge clk) disable iff (rst)
    adv && need_nl |=> col == 8'd0 && out_valid && !out_last)
    else $error("newline did not restart the line");

  a_last_not_nl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_char != b64e_pkg::NEWLINE_CHAR)
    else $error("item ended on a newline");

  a_msg_end_col: assert property (@(posedge clk) disable iff (rst)
    adv && !need_nl && final_char && head.is_last |=> col == 8'd0 && idx == 2'd0)
    else $error("column not cleared at end of message");

endmodule
